[src/ctxpp_pkg.sv]
// Shared types, field codes and layout constants of the context packet parser.
package ctxpp_pkg;

  // Bytes of the 16-byte UUID field
  localparam logic [4:0] UUID_LEN = 5'd16;

  // Field codes, in layout order
  typedef enum logic [4:0] {
    F_REQUEST       = 5'd0,
    F_PROFILE       = 5'd1,
    F_VERSION       = 5'd2,
    F_CHANNEL       = 5'd3,
    F_UUID          = 5'd4,
    F_IP            = 5'd5,
    F_PORT          = 5'd6,
    F_TIME          = 5'd7,
    F_HEAD_TYPE     = 5'd8,
    F_HEAD_LEN      = 5'd9,
    F_HEAD_DATA     = 5'd10,
    F_CI_TYPE       = 5'd11,
    F_ROOT_CONTENT  = 5'd12,
    F_ROOT_MASK     = 5'd13,
    F_BRICK_COUNT   = 5'd14,
    F_BRICK_CONTENT = 5'd15,
    F_BRICK_MASK    = 5'd16,
    F_APP_TYPE      = 5'd17,
    F_APP_LEN       = 5'd18,
    F_APP_DATA      = 5'd19,
    F_OVERFLOW      = 5'd20
  } field_t;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SHORT  = 2'd1,
    ERR_BEYOND = 2'd2
  } err_t;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0] byte_echo;
    logic [4:0] field_code;
    logic [7:0] field_offset;
    logic       packet_done;
    logic       packet_ok;
    logic [1:0] error_code;
  } out_word_t;

  // Size of the fixed-length fields; variable fields return zero
  function automatic logic [4:0] fixed_size(input field_t f);
    logic [4:0] sz;
    unique case (f)
      F_UUID: sz = UUID_LEN;
      F_IP:   sz = 5'd4;
      F_PORT: sz = 5'd2;
      F_TIME: sz = 5'd8;
      F_HEAD_DATA, F_BRICK_CONTENT, F_BRICK_MASK, F_APP_DATA, F_OVERFLOW: sz = 5'd0;
      default: sz = 5'd1;
    endcase
    return sz;
  endfunction

endpackage

[src/ctxpp_in_stage.sv]
// Input register of the parser: captures one word whenever it is free or draining.
module ctxpp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ctxpp_pkg::in_word_t in_word,
  input  logic                advance,
  output logic                s1_valid,
  output ctxpp_pkg::in_word_t s1_word
);
  import ctxpp_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  in_word_t s1_word_r;
  logic     accept;

  // Hold off the sender only while a word sits here and cannot move on
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word_r <= in_word;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_word  = s1_word_r;

endmodule

[src/ctxpp_tracker.sv]
// Field tracker: tags the staged byte with field and offset and checks packet length.
module ctxpp_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  ctxpp_pkg::in_word_t  s1_word,
  output ctxpp_pkg::out_word_t result
);
  import ctxpp_pkg::*;

  field_t     cur_r, cur_nxt, cur_upd;
  logic [7:0] off_r, off_nxt, off_upd, off_inc;
  logic [8:0] rem_r, rem_nxt, rem_upd, rem_dec;
  logic       ovf_r, ovf_nxt, ovf_upd;
  logic [7:0] b;
  logic       last;
  err_t       err;
  logic       ok;

  assign b       = s1_word.data_byte;
  assign last    = s1_word.end_of_packet;
  assign off_inc = off_r + 8'd1;
  assign rem_dec = rem_r - 9'd1;

  // Walk the layout one byte
  always_comb begin
    cur_upd = cur_r;
    off_upd = off_r;
    rem_upd = rem_r;
    ovf_upd = ovf_r;
    unique case (cur_r)
      F_OVERFLOW: begin
        ovf_upd = 1'b1;
        if (off_r != 8'hFF) begin
          off_upd = off_inc;
        end
      end
      F_HEAD_LEN: begin
        off_upd = 8'd0;
        if (b != 8'd0) begin
          cur_upd = F_HEAD_DATA;
          rem_upd = {1'b0, b};
        end else begin
          cur_upd = F_CI_TYPE;
          rem_upd = 9'd0;
        end
      end
      F_BRICK_COUNT: begin
        off_upd = 8'd0;
        if (b != 8'd0) begin
          cur_upd = F_BRICK_CONTENT;
          rem_upd = {b, 1'b0};
        end else begin
          cur_upd = F_APP_TYPE;
          rem_upd = 9'd0;
        end
      end
      F_APP_LEN: begin
        off_upd = 8'd0;
        if (b != 8'd0) begin
          cur_upd = F_APP_DATA;
          rem_upd = {1'b0, b};
        end else begin
          cur_upd = F_OVERFLOW;
          rem_upd = 9'd0;
        end
      end
      F_HEAD_DATA, F_APP_DATA: begin
        rem_upd = rem_dec;
        off_upd = off_inc;
        if (rem_dec == 9'd0) begin
          cur_upd = (cur_r == F_HEAD_DATA) ? F_CI_TYPE : F_OVERFLOW;
          off_upd = 8'd0;
        end
      end
      F_BRICK_CONTENT: begin
        rem_upd = rem_dec;
        cur_upd = F_BRICK_MASK;
      end
      F_BRICK_MASK: begin
        rem_upd = rem_dec;
        off_upd = off_inc;
        cur_upd = F_BRICK_CONTENT;
        if (rem_dec == 9'd0) begin
          cur_upd = F_APP_TYPE;
          off_upd = 8'd0;
        end
      end
      default: begin
        // fixed-size fields
        off_upd = off_inc;
        if (off_inc >= {3'b000, fixed_size(cur_r)}) begin
          cur_upd = field_t'(cur_r + 5'd1);
          off_upd = 8'd0;
          rem_upd = 9'd0;
        end
      end
    endcase
  end

  // End-of-packet verdict and return to the start of the layout
  always_comb begin
    err     = (cur_r == F_OVERFLOW) ? ERR_BEYOND : ERR_NONE;
    ok      = 1'b0;
    cur_nxt = cur_upd;
    off_nxt = off_upd;
    rem_nxt = rem_upd;
    ovf_nxt = ovf_upd;
    if (last) begin
      priority if (cur_r == F_OVERFLOW || ovf_r) begin
        err = ERR_BEYOND;
      end else if (cur_upd == F_OVERFLOW) begin
        ok = 1'b1;
      end else begin
        err = ERR_SHORT;
      end
      cur_nxt = F_REQUEST;
      off_nxt = 8'd0;
      rem_nxt = 9'd0;
      ovf_nxt = 1'b0;
    end
  end

  always_comb begin
    result.byte_echo    = b;
    result.field_code   = cur_r;
    result.field_offset = off_r;
    result.packet_done  = last;
    result.packet_ok    = ok;
    result.error_code   = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= F_REQUEST;
      off_r <= 8'd0;
      rem_r <= 9'd0;
      ovf_r <= 1'b0;
    end else if (step) begin
      cur_r <= cur_nxt;
      off_r <= off_nxt;
      rem_r <= rem_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

[src/ctxpp_out_stage.sv]
// Result register: holds a tagged word until the receiver takes it.
module ctxpp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s1_valid,
  input  ctxpp_pkg::out_word_t result,
  output logic                 advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctxpp_pkg::out_word_t out_word
);
  import ctxpp_pkg::*;

  logic      out_valid_r;
  out_word_t out_word_r;

  // Register is free when empty or being taken this cycle
  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[src/context_packet_parser_checker.sv]
// Top level of the context packet parser and length checker.
// Takes one packet byte per cycle (data_byte with an end_of_packet mark on the final byte)
// and returns one word per byte: the byte, its field code, its offset in the field (brick
// index for brick bytes, overflow count for overflow bytes) and, on the final byte, whether
// the packet length matches 42 + head length + 2 * brick count + app length. A byte is
// tagged from the input register into the result register; a new byte is taken every
// cycle unless the output stalls, since the tracker's field state advances by one byte
// per cycle in a single pass. After a final byte the layout restarts at the request field.
module context_packet_parser_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ctxpp_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ctxpp_pkg::out_word_t out_word
);
  import ctxpp_pkg::*;

  logic      advance;
  logic      s1_valid;
  in_word_t  s1_word;
  out_word_t result;

  ctxpp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_word  (s1_word)
  );

  ctxpp_tracker u_trk (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance && s1_valid),
    .s1_word (s1_word),
    .result  (result)
  );

  ctxpp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[src/ctxpp_checker.sv]
// Port-level assertions for the context packet parser, bound to the top level.
module ctxpp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input ctxpp_pkg::out_word_t out_word
);
  import ctxpp_pkg::*;

  // A good packet is only reported on its final word, without an error
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.packet_ok |-> out_word.packet_done &&
      (out_word.error_code == ERR_NONE))
    else $error("packet_ok without clean packet_done");

  // Overflow bytes always carry the beyond-layout error
  a_ovf_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.field_code == F_OVERFLOW) |->
      (out_word.error_code == ERR_BEYOND))
    else $error("overflow word without beyond-layout error");

  // A short-packet error only shows on a final word
  a_short_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.error_code == ERR_SHORT) |-> out_word.packet_done)
    else $error("short-packet error on a non-final word");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

endmodule

bind context_packet_parser_checker ctxpp_checker u_ctxpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
